// ===== design/mcml_pkg.sv =====
package mcml_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int PARAM_BITS  = 8;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);

  localparam logic [4:0] CHANNEL_MAX = 5'd16;
  localparam logic [4:0] CHANNEL_OMNI = 5'd0;

  localparam logic [2:0] OP_CTRL     = 3'd0;
  localparam logic [2:0] OP_LEARN    = 3'd1;
  localparam logic [2:0] OP_CANCEL   = 3'd2;
  localparam logic [2:0] OP_SET      = 3'd3;
  localparam logic [2:0] OP_RM_PARAM = 3'd4;
  localparam logic [2:0] OP_RM_CC    = 3'd5;
  localparam logic [2:0] OP_CLEAR    = 3'd6;
  localparam logic [2:0] OP_QUERY    = 3'd7;

  localparam logic [2:0] KIND_UPDATE = 3'd0;
  localparam logic [2:0] KIND_HIT    = 3'd1;
  localparam logic [2:0] KIND_MISS   = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_FULL   = 3'd4;

  typedef struct packed {
    logic [PARAM_BITS-1:0] param;
    logic [6:0]            cc;
    logic [4:0]            channel;
  } entry_t;

endpackage

// ===== design/midi_cc_learn_map_table_unit.sv =====
// Start learn, cancel learn and clear finish at once: the result strobe is registered and
// comes in the cycle after acceptance; the next transaction may be accepted in that same cycle.
// All other operations scan the entry memory one entry per cycle; a set or learn capture
// then inserts. Their registered result strobe comes as busy falls, and the next
// transaction may be accepted then. A control change matching no entry gives no strobe.
// The receiver cannot stall; reset clears the valid bits, learn state and the strobe.
module midi_cc_learn_map_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] operation_i,
  input  logic [7:0] param_index_i,
  input  logic [6:0] cc_number_i,
  input  logic [4:0] channel_i,
  input  logic [6:0] cc_value_i,
  output logic       result_valid_o,
  output logic [2:0] result_kind_o,
  output logic [7:0] target_param_o,
  output logic [6:0] mapped_cc_o,
  output logic [4:0] mapped_channel_o,
  output logic [6:0] update_value_o,
  output logic       from_learn_o
);
  import mcml_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic learn_active_q, learn_active_d;
  logic [PARAM_BITS-1:0] learn_target_q, learn_target_d;

  logic [2:0] op_q, op_d;
  logic capture_q, capture_d;
  logic [PARAM_BITS-1:0] param_q, param_d;
  logic [6:0] cc_q, cc_d;
  logic [4:0] ch_q, ch_d;
  logic [6:0] value_q, value_d;

  logic [IDX_BITS:0] addr_q, addr_d;
  logic rd_vld_q, rd_vld_d;
  logic [IDX_BITS-1:0] rd_idx_q, rd_idx_d;
  logic found_q, found_d;
  entry_t hit_q, hit_d;
  logic free_found_q, free_found_d;
  logic [IDX_BITS-1:0] free_idx_q, free_idx_d;

  logic res_vld_q, res_vld_d;
  logic [2:0] res_kind_q, res_kind_d;
  logic [7:0] res_param_q, res_param_d;
  logic [6:0] res_cc_q, res_cc_d;
  logic [4:0] res_ch_q, res_ch_d;
  logic [6:0] res_val_q, res_val_d;
  logic res_learn_q, res_learn_d;

  logic ram_we;
  logic ram_re;
  entry_t ram_wdata;
  entry_t ram_rdata;

  logic accept;
  logic ent_v;
  logic cc_eq;
  logic param_eq;
  logic drop_p;
  logic drop_c;
  logic drop;
  logic is_match;
  logic [PARAM_BITS-1:0] in_param;
  logic [4:0] sat_ch;

  mcml_entry_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(addr_q[IDX_BITS-1:0]),
    .rdata_o(ram_rdata)
  );

  assign accept    = start && (state_q == S_IDLE);
  assign in_param  = param_index_i[PARAM_BITS-1:0];
  assign sat_ch    = (channel_i > CHANNEL_MAX) ? CHANNEL_MAX : channel_i;
  assign ram_re    = (state_q == S_SCAN) && !addr_q[IDX_BITS];
  assign ram_wdata = '{param: param_q, cc: cc_q, channel: ch_q};

  assign ent_v    = rd_vld_q && valid_q[rd_idx_q];
  assign cc_eq    = ram_rdata.cc == cc_q;
  assign param_eq = ram_rdata.param == param_q;
  assign drop_p   = ent_v && param_eq &&
                    (capture_q || (op_q == OP_SET) || (op_q == OP_RM_PARAM));
  assign drop_c   = ent_v && cc_eq &&
                    (capture_q || (((op_q == OP_SET) || (op_q == OP_RM_CC)) &&
                     ((ch_q == CHANNEL_OMNI) || (ram_rdata.channel == CHANNEL_OMNI) ||
                      (ram_rdata.channel == ch_q))));
  assign drop     = drop_p || drop_c;
  assign is_match = ent_v && !capture_q &&
                    (((op_q == OP_CTRL) && cc_eq &&
                      ((ram_rdata.channel == CHANNEL_OMNI) || (ram_rdata.channel == ch_q))) ||
                     ((op_q == OP_QUERY) && param_eq));

  always_comb begin
    state_d        = state_q;
    valid_d        = valid_q;
    learn_active_d = learn_active_q;
    learn_target_d = learn_target_q;
    op_d           = op_q;
    capture_d      = capture_q;
    param_d        = param_q;
    cc_d           = cc_q;
    ch_d           = ch_q;
    value_d        = value_q;
    addr_d         = addr_q;
    rd_vld_d       = 1'b0;
    rd_idx_d       = rd_idx_q;
    found_d        = found_q;
    hit_d          = hit_q;
    free_found_d   = free_found_q;
    free_idx_d     = free_idx_q;
    res_vld_d      = 1'b0;
    res_kind_d     = res_kind_q;
    res_param_d    = res_param_q;
    res_cc_d       = res_cc_q;
    res_ch_d       = res_ch_q;
    res_val_d      = res_val_q;
    res_learn_d    = res_learn_q;
    ram_we         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = operation_i;
          capture_d    = 1'b0;
          param_d      = in_param;
          cc_d         = cc_number_i;
          ch_d         = channel_i;
          value_d      = cc_value_i;
          addr_d       = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          res_kind_d   = KIND_DONE;
          res_param_d  = '0;
          res_cc_d     = '0;
          res_ch_d     = '0;
          res_val_d    = '0;
          res_learn_d  = 1'b0;
          unique case (operation_i)
            OP_CTRL: begin
              state_d = S_SCAN;
              if (learn_active_q) begin
                capture_d      = 1'b1;
                param_d        = learn_target_q;
                ch_d           = CHANNEL_OMNI;
                learn_active_d = 1'b0;
                learn_target_d = '0;
              end
            end
            OP_LEARN: begin
              learn_active_d = 1'b1;
              learn_target_d = in_param;
              res_vld_d      = 1'b1;
            end
            OP_CANCEL: begin
              learn_active_d = 1'b0;
              learn_target_d = '0;
              res_vld_d      = 1'b1;
            end
            OP_SET: begin
              ch_d    = sat_ch;
              state_d = S_SCAN;
            end
            OP_CLEAR: begin
              valid_d        = '0;
              learn_active_d = 1'b0;
              learn_target_d = '0;
              res_vld_d      = 1'b1;
            end
            OP_RM_PARAM, OP_RM_CC, OP_QUERY: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ram_re) begin
          addr_d   = addr_q + 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q[IDX_BITS-1:0];
        end
        if (rd_vld_q) begin
          if (drop) begin
            valid_d[rd_idx_q] = 1'b0;
          end
          if (is_match && !found_q) begin
            found_d = 1'b1;
            hit_d   = ram_rdata;
          end
          if ((!valid_q[rd_idx_q] || drop) && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = rd_idx_q;
          end
          if (rd_idx_q == IDX_BITS'(TABLE_DEPTH - 1)) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
        if (capture_q || (op_q == OP_SET)) begin
          res_vld_d = 1'b1;
          if (free_found_q) begin
            ram_we              = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            if (capture_q) begin
              res_kind_d  = KIND_UPDATE;
              res_param_d = 8'(param_q);
              res_cc_d    = cc_q;
              res_val_d   = value_q;
              res_learn_d = 1'b1;
            end
          end else begin
            res_kind_d  = KIND_FULL;
            res_param_d = 8'(param_q);
            res_cc_d    = cc_q;
            res_ch_d    = ch_q;
          end
        end else if (op_q == OP_CTRL) begin
          if (found_q) begin
            res_vld_d   = 1'b1;
            res_kind_d  = KIND_UPDATE;
            res_param_d = 8'(hit_q.param);
            res_cc_d    = hit_q.cc;
            res_ch_d    = hit_q.channel;
            res_val_d   = value_q;
          end
        end else if (op_q == OP_QUERY) begin
          res_vld_d   = 1'b1;
          res_param_d = 8'(param_q);
          if (found_q) begin
            res_kind_d = KIND_HIT;
            res_cc_d   = hit_q.cc;
            res_ch_d   = hit_q.channel;
          end else begin
            res_kind_d = KIND_MISS;
          end
        end else begin
          res_vld_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      valid_q        <= '0;
      learn_active_q <= 1'b0;
      learn_target_q <= '0;
      rd_vld_q       <= 1'b0;
      res_vld_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      valid_q        <= valid_d;
      learn_active_q <= learn_active_d;
      learn_target_q <= learn_target_d;
      rd_vld_q       <= rd_vld_d;
      res_vld_q      <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    capture_q    <= capture_d;
    param_q      <= param_d;
    cc_q         <= cc_d;
    ch_q         <= ch_d;
    value_q      <= value_d;
    addr_q       <= addr_d;
    rd_idx_q     <= rd_idx_d;
    found_q      <= found_d;
    hit_q        <= hit_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    res_kind_q   <= res_kind_d;
    res_param_q  <= res_param_d;
    res_cc_q     <= res_cc_d;
    res_ch_q     <= res_ch_d;
    res_val_q    <= res_val_d;
    res_learn_q  <= res_learn_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = res_vld_q;
  assign result_kind_o    = res_kind_q;
  assign target_param_o   = res_param_q;
  assign mapped_cc_o      = res_cc_q;
  assign mapped_channel_o = res_ch_q;
  assign update_value_o   = res_val_q;
  assign from_learn_o     = res_learn_q;

  a_insert_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !valid_q[free_idx_q])
    else $error("Insert targets an occupied slot.");

  a_no_result_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !res_vld_q)
    else $error("Result strobe during a table scan.");

  a_learn_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_LEARN)) |=>
      (res_vld_q && (res_kind_q == KIND_DONE) && learn_active_q))
    else $error("Start learn did not complete at once.");

  a_learn_omni: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_learn_q) |-> ((res_ch_q == CHANNEL_OMNI) && !learn_active_q))
    else $error("Learn capture not omni or learn still active.");

endmodule

// ===== design/mcml_entry_ram.sv =====
module mcml_entry_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [mcml_pkg::IDX_BITS-1:0] waddr_i,
  input  mcml_pkg::entry_t         wdata_i,
  input  logic                     re_i,
  input  logic [mcml_pkg::IDX_BITS-1:0] raddr_i,
  output mcml_pkg::entry_t         rdata_o
);
  import mcml_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/midi_cc_learn_map_table_unit_test.sv =====
module midi_cc_learn_map_table_unit_test;
  import mcml_pkg::*;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] param;
    logic [6:0] cc;
    logic [4:0] ch;
    logic [6:0] value;
  } request_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] param;
    logic [6:0] cc;
    logic [4:0] ch;
    logic [6:0] value;
    logic       learned;
  } outcome_t;

  typedef enum logic [1:0] {ROW_FOLLOW, ROW_RESULT, ROW_SILENT} row_check_e;

  typedef struct packed {
    request_t   req;
    row_check_e how;
    outcome_t   pinned;
  } row_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_IDLE [4] = '{0, 51, 0, 14};
  localparam outcome_t NO_OUTCOME = '0;
  localparam outcome_t DONE_OUT = '{KIND_DONE, 8'd0, 7'd0, 5'd0, 7'd0, 1'b0};

  localparam row_t DIRECTED [25] = '{
    '{'{OP_QUERY, 8'd0, 7'd0, 5'd0, 7'd0}, ROW_RESULT,
      '{KIND_MISS, 8'd0, 7'd0, 5'd0, 7'd0, 1'b0}},
    '{'{OP_CTRL, 8'd0, 7'd0, 5'd0, 7'd0}, ROW_SILENT, NO_OUTCOME},
    '{'{OP_SET, 8'd255, 7'd127, 5'd16, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_QUERY, 8'd255, 7'd0, 5'd0, 7'd0}, ROW_RESULT,
      '{KIND_HIT, 8'd255, 7'd127, 5'd16, 7'd0, 1'b0}},
    '{'{OP_CTRL, 8'd0, 7'd127, 5'd16, 7'd127}, ROW_RESULT,
      '{KIND_UPDATE, 8'd255, 7'd127, 5'd16, 7'd127, 1'b0}},
    '{'{OP_CTRL, 8'd0, 7'd127, 5'd0, 7'd5}, ROW_SILENT, NO_OUTCOME},
    '{'{OP_SET, 8'd0, 7'd0, 5'd31, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_QUERY, 8'd0, 7'd0, 5'd0, 7'd0}, ROW_RESULT,
      '{KIND_HIT, 8'd0, 7'd0, 5'd16, 7'd0, 1'b0}},
    '{'{OP_SET, 8'd1, 7'd0, 5'd0, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_QUERY, 8'd0, 7'd0, 5'd0, 7'd0}, ROW_RESULT,
      '{KIND_MISS, 8'd0, 7'd0, 5'd0, 7'd0, 1'b0}},
    '{'{OP_CTRL, 8'd0, 7'd0, 5'd31, 7'd64}, ROW_RESULT,
      '{KIND_UPDATE, 8'd1, 7'd0, 5'd0, 7'd64, 1'b0}},
    '{'{OP_LEARN, 8'd200, 7'd0, 5'd0, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_LEARN, 8'd77, 7'd0, 5'd0, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_CTRL, 8'd0, 7'd127, 5'd3, 7'd99}, ROW_RESULT,
      '{KIND_UPDATE, 8'd77, 7'd127, 5'd0, 7'd99, 1'b1}},
    '{'{OP_QUERY, 8'd255, 7'd0, 5'd0, 7'd0}, ROW_RESULT,
      '{KIND_MISS, 8'd255, 7'd0, 5'd0, 7'd0, 1'b0}},
    '{'{OP_LEARN, 8'd5, 7'd0, 5'd0, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_CANCEL, 8'd170, 7'd85, 5'd21, 7'd42}, ROW_RESULT, DONE_OUT},
    '{'{OP_CTRL, 8'd0, 7'd50, 5'd1, 7'd1}, ROW_SILENT, NO_OUTCOME},
    '{'{OP_RM_CC, 8'd0, 7'd127, 5'd5, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_RM_PARAM, 8'd1, 7'd0, 5'd0, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_RM_CC, 8'd0, 7'd3, 5'd31, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_SET, 8'd10, 7'd10, 5'd10, 7'd0}, ROW_FOLLOW, NO_OUTCOME},
    '{'{OP_LEARN, 8'd10, 7'd0, 5'd0, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_CLEAR, 8'd0, 7'd0, 5'd0, 7'd0}, ROW_RESULT, DONE_OUT},
    '{'{OP_QUERY, 8'd10, 7'd0, 5'd0, 7'd0}, ROW_RESULT,
      '{KIND_MISS, 8'd10, 7'd0, 5'd0, 7'd0, 1'b0}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] operation_i = '0;
  logic [7:0] param_index_i = '0;
  logic [6:0] cc_number_i = '0;
  logic [4:0] channel_i = '0;
  logic [6:0] cc_value_i = '0;
  logic       result_valid_o;
  logic [2:0] result_kind_o;
  logic [7:0] target_param_o;
  logic [6:0] mapped_cc_o;
  logic [4:0] mapped_channel_o;
  logic [6:0] update_value_o;
  logic       from_learn_o;

  row_check_e row_how = ROW_FOLLOW;
  outcome_t   row_pinned = '0;

  bit          map_valid [TABLE_DEPTH] = '{default: 1'b0};
  entry_t      map_entry [TABLE_DEPTH];
  bit          learn_on = 1'b0;
  logic [7:0]  learn_param = '0;
  outcome_t    expected_results [$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int          idle_pct = 0;

  midi_cc_learn_map_table_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .param_index_i   (param_index_i),
    .cc_number_i     (cc_number_i),
    .channel_i       (channel_i),
    .cc_value_i      (cc_value_i),
    .result_valid_o  (result_valid_o),
    .result_kind_o   (result_kind_o),
    .target_param_o  (target_param_o),
    .mapped_cc_o     (mapped_cc_o),
    .mapped_channel_o(mapped_channel_o),
    .update_value_o  (update_value_o),
    .from_learn_o    (from_learn_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void drop_param(input logic [7:0] param);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (map_valid[i] && map_entry[i].param == param) map_valid[i] = 1'b0;
    end
  endfunction

  function automatic void drop_cc(input logic [6:0] cc, input logic [4:0] ch,
                                  input bit any_channel);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (map_valid[i] && map_entry[i].cc == cc &&
          (any_channel || ch == CHANNEL_OMNI || map_entry[i].channel == CHANNEL_OMNI ||
           map_entry[i].channel == ch)) begin
        map_valid[i] = 1'b0;
      end
    end
  endfunction

  function automatic bit insert_entry(input logic [7:0] param, input logic [6:0] cc,
                                      input logic [4:0] ch);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!map_valid[i]) begin
        map_valid[i] = 1'b1;
        map_entry[i] = '{param, cc, ch};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one transaction to the table copy; returns 1 when it yields a result.
  function automatic bit apply_request(input request_t r, output outcome_t o);
    logic [4:0] ch;
    logic [7:0] target;
    o = '0;
    ch = r.ch;
    case (r.op)
      OP_CTRL: begin
        if (learn_on) begin
          target = learn_param;
          learn_on = 1'b0;
          learn_param = '0;
          drop_param(target);
          drop_cc(r.cc, CHANNEL_OMNI, 1'b1);
          o.param = target;
          o.cc = r.cc;
          if (!insert_entry(target, r.cc, CHANNEL_OMNI)) begin
            o.kind = KIND_FULL;
          end else begin
            o.kind = KIND_UPDATE;
            o.value = r.value;
            o.learned = 1'b1;
          end
          return 1'b1;
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (map_valid[i] && map_entry[i].cc == r.cc &&
              (map_entry[i].channel == CHANNEL_OMNI || map_entry[i].channel == r.ch)) begin
            o = '{KIND_UPDATE, map_entry[i].param, map_entry[i].cc, map_entry[i].channel,
                  r.value, 1'b0};
            return 1'b1;
          end
        end
        return 1'b0;
      end
      OP_LEARN: begin
        learn_param = r.param;
        learn_on = 1'b1;
      end
      OP_CANCEL: begin
        learn_on = 1'b0;
        learn_param = '0;
      end
      OP_SET: begin
        if (ch > CHANNEL_MAX) ch = CHANNEL_MAX;
        drop_param(r.param);
        drop_cc(r.cc, ch, 1'b0);
        if (!insert_entry(r.param, r.cc, ch)) begin
          o = '{KIND_FULL, r.param, r.cc, ch, 7'd0, 1'b0};
          return 1'b1;
        end
      end
      OP_RM_PARAM: drop_param(r.param);
      OP_RM_CC: drop_cc(r.cc, r.ch, 1'b0);
      OP_CLEAR: begin
        map_valid = '{default: 1'b0};
        learn_on = 1'b0;
        learn_param = '0;
      end
      default: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (map_valid[i] && map_entry[i].param == r.param) begin
            o = '{KIND_HIT, r.param, map_entry[i].cc, map_entry[i].channel, 7'd0, 1'b0};
            return 1'b1;
          end
        end
        o.kind = KIND_MISS;
        o.param = r.param;
        return 1'b1;
      end
    endcase
    o.kind = KIND_DONE;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic send_item(input request_t r, input row_check_e how, input outcome_t pinned);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= r.op;
    param_index_i <= r.param;
    cc_number_i <= r.cc;
    channel_i <= r.ch;
    cc_value_i <= r.value;
    row_how <= how;
    row_pinned <= pinned;
    do @(posedge clk_i); while (!(start && !busy));
  endtask

  // Fills the table from empty past its depth, then lets a learn capture hit the full table.
  task automatic fill_table();
    request_t r;
    int base;
    base = $urandom_range(200);
    r = '0;
    r.op = OP_CLEAR;
    send_item(r, ROW_FOLLOW, NO_OUTCOME);
    for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
      r.op = OP_SET;
      r.param = 8'(base + i);
      r.cc = 7'(i);
      r.ch = 5'($urandom_range(1, 16));
      r.value = 7'($urandom_range(127));
      send_item(r, ROW_FOLLOW, NO_OUTCOME);
    end
    r.op = OP_LEARN;
    r.param = 8'(base + 40);
    send_item(r, ROW_FOLLOW, NO_OUTCOME);
    r.op = OP_CTRL;
    r.cc = 7'($urandom_range(100, 127));
    send_item(r, ROW_FOLLOW, NO_OUTCOME);
  endtask

  always @(posedge clk_i) begin : transaction_track
    outcome_t got;
    outcome_t want;
    outcome_t predicted;
    request_t req;
    bit       has_result;
    if (rst_ni) begin
      if (result_valid_o) begin
        got = '{result_kind_o, target_param_o, mapped_cc_o, mapped_channel_o,
                update_value_o, from_learn_o};
        if (expected_results.size() == 0) begin
          $display("%0t: result kind %0d with no transaction pending", $time, got.kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(got.kind));
          check_field("target_param", 32'(want.param), 32'(got.param));
          check_field("mapped_cc", 32'(want.cc), 32'(got.cc));
          check_field("mapped_channel", 32'(want.ch), 32'(got.ch));
          check_field("update_value", 32'(want.value), 32'(got.value));
          check_field("from_learn", 32'(want.learned), 32'(got.learned));
        end
      end
      if (start && !busy) begin
        req = '{operation_i, param_index_i, cc_number_i, channel_i, cc_value_i};
        has_result = apply_request(req, predicted);
        case (row_how)
          ROW_RESULT: expected_results = {expected_results, row_pinned};
          ROW_SILENT: ;
          default: if (has_result) expected_results = {expected_results, predicted};
        endcase
      end
      if (result_valid_o || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[midi_cc_learn_map_table_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    request_t r;
    int pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DIRECTED[k]) send_item(DIRECTED[k].req, DIRECTED[k].how, DIRECTED[k].pinned);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = PHASE_IDLE[ph];
      fill_table();
      repeat (400) begin
        r.value = 7'($urandom_range(127));
        r.param = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(39));
        r.cc = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(39));
        r.ch = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
        pick = $urandom_range(99);
        if (pick < 30) r.op = OP_CTRL;
        else if (pick < 58) r.op = OP_SET;
        else if (pick < 70) r.op = OP_QUERY;
        else if (pick < 77) r.op = OP_LEARN;
        else if (pick < 80) r.op = OP_CANCEL;
        else if (pick < 88) r.op = OP_RM_PARAM;
        else if (pick < 98) r.op = OP_RM_CC;
        else r.op = OP_CLEAR;
        send_item(r, ROW_FOLLOW, NO_OUTCOME);
      end
    end
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[midi_cc_learn_map_table_unit] OK");
    end else begin
      $display("[midi_cc_learn_map_table_unit] ERROR");
    end
    $finish;
  end

endmodule
